// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/dorf_pkg.sv
// ----------------------------------------------------------------------------
// dorf_pkg
// Types, command codes and defaults for the drop-oldest ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dorf_pkg;

	localparam int DEF_RING_DEPTH  = 1024;
	localparam int DEF_PACKET_BITS = 64;

	localparam int PKT_FIELD_W   = 64;
	localparam int LEVEL_FIELD_W = 11;
	localparam int TOTAL_W       = 32;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                   command;
		logic [PKT_FIELD_W-1:0] packet_in;
	} in_item_t;

	typedef struct packed {
		logic                     status;
		logic [PKT_FIELD_W-1:0]   packet_out;
		logic                     packet_valid;
		logic                     dropped_now;
		logic [LEVEL_FIELD_W-1:0] fill_level;
		logic [LEVEL_FIELD_W-1:0] free_space;
		logic                     is_full;
		logic                     is_empty;
		logic [TOTAL_W-1:0]       dropped_total;
		logic [TOTAL_W-1:0]       written_total;
		logic [TOTAL_W-1:0]       replayed_total;
	} out_item_t;

	// per-command result flags from the control unit
	typedef struct packed {
		logic status;
		logic pvalid;
		logic dropped;
	} step_flags_t;

endpackage

// File: rtl/dorf_ram.sv
// ----------------------------------------------------------------------------
// dorf_ram
// Simple dual-port ring memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dorf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/dorf_ctrl.sv
// ----------------------------------------------------------------------------
// dorf_ctrl
// Pointer, fill count and total counters; issues at most one memory access per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dorf_ctrl #(
	parameter int RING_DEPTH  = 1024,
	parameter int PACKET_BITS = 64,
	localparam int AW = $clog2(RING_DEPTH),
	localparam int CW = $clog2(RING_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  dorf_pkg::in_item_t     beat,
	output dorf_pkg::step_flags_t  flags,
	output logic [CW-1:0]          held,
	output logic [31:0]            drop_total,
	output logic [31:0]            write_total,
	output logic [31:0]            replay_total,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [PACKET_BITS-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr
);

	import dorf_pkg::*;

	logic [AW-1:0] wp_q, rp_q, wp_d, rp_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   drop_q, write_q, replay_q;
	logic          full, empty, we, re, do_write, do_replay;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full  = (cnt_q == CW'(RING_DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		flags     = '0;
		we        = 1'b0;
		re        = 1'b0;
		do_write  = 1'b0;
		do_replay = 1'b0;
		wp_d      = wp_q;
		rp_d      = rp_q;
		cnt_d     = cnt_q;
		case (beat.command)
			CMD_ENQUEUE: begin
				we       = 1'b1;
				do_write = 1'b1;
				wp_d     = nxt(wp_q);
				if (full) begin
					// overwrite the oldest: head moves, level stays
					rp_d          = nxt(rp_q);
					flags.dropped = 1'b1;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			CMD_DEQUEUE, CMD_PEEK: begin
				if (empty) begin
					flags.status = 1'b1;
				end else begin
					re           = 1'b1;
					flags.pvalid = 1'b1;
					if (beat.command == CMD_DEQUEUE) begin
						do_replay = 1'b1;
						rp_d      = nxt(rp_q);
						cnt_d     = cnt_q - CW'(1);
					end
				end
			end
			CMD_CLEAR: begin
				wp_d  = '0;
				rp_d  = '0;
				cnt_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			drop_q   <= '0;
			write_q  <= '0;
			replay_q <= '0;
		end else if (fire) begin
			wp_q  <= wp_d;
			rp_q  <= rp_d;
			cnt_q <= cnt_d;
			if (flags.dropped) drop_q   <= drop_q + 32'd1;
			if (do_write)      write_q  <= write_q + 32'd1;
			if (do_replay)     replay_q <= replay_q + 32'd1;
		end
	end

	assign mem_we    = fire && we;
	assign mem_waddr = wp_q;
	assign mem_wdata = beat.packet_in[PACKET_BITS-1:0];
	assign mem_re    = fire && re;
	assign mem_raddr = rp_q;

	assign held         = cnt_q;
	assign drop_total   = drop_q;
	assign write_total  = write_q;
	assign replay_total = replay_q;

endmodule

// File: rtl/drop_oldest_ring_fifo_core.sv
// ----------------------------------------------------------------------------
// drop_oldest_ring_fifo_core
// Packet FIFO in one ring memory; a full enqueue drops the oldest entry.
// ----------------------------------------------------------------------------
//  channel | handshake             | beat type  | per beat
//  cmd     | cmd_valid / cmd_stall | in_item_t  | command, packet word
//  rsp     | rsp_valid / rsp_stall | out_item_t | status, head packet, levels
//
//  One command per cycle while the response side is not stalled; its response
//  appears in the cycle after acceptance, set by the registered ring read.
//  Pointers and counts sit in flops and update at acceptance, so reads never
//  overlap a write to the same entry.
//  Reset clears pointers, fill count and totals; the ring itself is not cleared.
//  A stalled response holds and stalls the command side behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drop_oldest_ring_fifo_core #(
	parameter int RING_DEPTH  = dorf_pkg::DEF_RING_DEPTH,
	parameter int PACKET_BITS = dorf_pkg::DEF_PACKET_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  dorf_pkg::in_item_t  cmd_beat,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dorf_pkg::out_item_t rsp_beat
);

	import dorf_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);

	logic                   fire;
	step_flags_t            flags, flags_s1;
	logic                   valid_s1;
	logic [CW-1:0]          held;
	logic [31:0]            drop_total, write_total, replay_total;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [PACKET_BITS-1:0] mem_wdata, mem_rdata;

	assign cmd_stall = valid_s1 && rsp_stall;
	assign fire      = cmd_valid && !cmd_stall;

	dorf_ctrl #(
		.RING_DEPTH (RING_DEPTH),
		.PACKET_BITS(PACKET_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.beat        (cmd_beat),
		.flags       (flags),
		.held        (held),
		.drop_total  (drop_total),
		.write_total (write_total),
		.replay_total(replay_total),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	dorf_ram #(
		.DEPTH(RING_DEPTH),
		.WIDTH(PACKET_BITS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_s1 <= flags;
		end
	end

	// level and totals only move on acceptance, so they track the held beat
	always_comb begin
		rsp_beat                = '0;
		rsp_beat.status         = flags_s1.status;
		rsp_beat.packet_valid   = flags_s1.pvalid;
		rsp_beat.packet_out     = flags_s1.pvalid ? PKT_FIELD_W'(mem_rdata) : '0;
		rsp_beat.dropped_now    = flags_s1.dropped;
		rsp_beat.fill_level     = LEVEL_FIELD_W'(held);
		rsp_beat.free_space     = LEVEL_FIELD_W'(CW'(RING_DEPTH) - held);
		rsp_beat.is_full        = (held == CW'(RING_DEPTH));
		rsp_beat.is_empty       = (held == '0);
		rsp_beat.dropped_total  = drop_total;
		rsp_beat.written_total  = write_total;
		rsp_beat.replayed_total = replay_total;
	end

	assign rsp_valid = valid_s1;

endmodule

// File: rtl/dorf_checker.sv
// ----------------------------------------------------------------------------
// dorf_checker
// Port-level checks on the ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dorf_checker #(
	parameter int RING_DEPTH = dorf_pkg::DEF_RING_DEPTH
) (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input dorf_pkg::in_item_t  cmd_beat,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input dorf_pkg::out_item_t rsp_beat
);

	import dorf_pkg::*;

	logic sum_ok;
	logic clear_fire;

	assign sum_ok = (LEVEL_FIELD_W'(rsp_beat.fill_level + rsp_beat.free_space)
		== LEVEL_FIELD_W'(RING_DEPTH));
	assign clear_fire = cmd_valid && !cmd_stall && (cmd_beat.command == CMD_CLEAR);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall,
		rsp_valid && $stable(rsp_beat))
	`ASSERT_IMPLIES(a_level_sum, clk, arst_n, rsp_valid, sum_ok)
	`ASSERT_IMPLIES(a_drop_full, clk, arst_n, rsp_valid && rsp_beat.dropped_now,
		rsp_beat.is_full && !rsp_beat.status && !rsp_beat.packet_valid)
	`ASSERT_IMPLIES(a_empty_status, clk, arst_n, rsp_valid && rsp_beat.status,
		!rsp_beat.packet_valid && (rsp_beat.packet_out == '0))
	// a clear beat answers with an empty ring and no packet
	`ASSERT_NEXT(a_clear_empty, clk, arst_n, clear_fire,
		rsp_valid && rsp_beat.is_empty && !rsp_beat.status && !rsp_beat.packet_valid)

endmodule

bind drop_oldest_ring_fifo_core dorf_checker #(.RING_DEPTH(RING_DEPTH)) u_dorf_checker (.*);
